>>> rtl/mftt_pkg.sv
// shared types and constants for the motor feedback turn tracker
// no dependencies; imported by every module of the block except mftt_queue
`default_nettype none

package mftt_pkg;

    // field widths
    localparam int ID_W       = 11;
    localparam int POS_W      = 16;
    localparam int TURN_W     = 16;
    localparam int ANGLE_W    = 25;
    localparam int MOTOR_IX_W = 3;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_FIRST_MOTOR_ID = 3'd0;
    localparam logic [ID_W-1:0] FIRST_MOTOR_ID_RESET = 11'd513;

    // block sizing
    localparam int MOTOR_COUNT_DEF = 7;
    localparam int QUEUE_DEPTH     = 2;

    // turn arithmetic
    localparam int HALF_TURN    = 4096;
    localparam int DEG_PER_TURN = 360;
    localparam int COUNT_SHIFT  = 13;   // 8192 counts per turn

    // decoded payload of one frame
    typedef struct packed {
        logic        [15:0] position;
        logic signed [15:0] speed;
        logic signed [15:0] current;
        logic        [7:0]  temperature;
    } t_meas;

    // one result item
    typedef struct packed {
        logic        [MOTOR_IX_W-1:0] motor_index;
        logic        [15:0]           encoder_position;
        logic signed [15:0]           shaft_speed;
        logic signed [15:0]           measured_current;
        logic        [7:0]            temperature;
        logic signed [TURN_W-1:0]     turn_count;
        logic signed [ANGLE_W-1:0]    angle_degrees;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/mftt_queue.sv
// small first-in first-out buffer with full and empty flags
// depends on nothing but its parameters
`default_nettype none

module mftt_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mftt_front.sv
// front end: accepts frames, matches the id against the motor range, unpacks bytes
// depends on mftt_pkg
`default_nettype none

module mftt_front
    import mftt_pkg::*;
#(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF,
    localparam int SLOT_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1,
    localparam int MID_W  = SLOT_W + $bits(t_meas)
) (
    input  wire logic [ID_W-1:0]  i_first_id,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic [ID_W-1:0]  i_frame_id,
    input  wire logic [7:0]       i_byte0,
    input  wire logic [7:0]       i_byte1,
    input  wire logic [7:0]       i_byte2,
    input  wire logic [7:0]       i_byte3,
    input  wire logic [7:0]       i_byte4,
    input  wire logic [7:0]       i_byte5,
    input  wire logic [7:0]       i_byte6,
    output logic                  o_q_push,
    output logic [MID_W-1:0]      o_q_data,
    input  wire logic             i_q_full
);

    localparam logic [ID_W-1:0] COUNT_ID = ID_W'(MOTOR_COUNT);

    logic [ID_W-1:0] id_off;
    logic            in_range;
    t_meas           meas;

    assign id_off   = i_frame_id - i_first_id;
    // no wrap: id at or above the base and offset below the motor count
    assign in_range = (i_frame_id >= i_first_id) && (id_off < COUNT_ID);

    assign meas.position    = {i_byte0, i_byte1};
    assign meas.speed       = $signed({i_byte2, i_byte3});
    assign meas.current     = $signed({i_byte4, i_byte5});
    assign meas.temperature = i_byte6;

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full && in_range;
    assign o_q_data = {id_off[SLOT_W-1:0], meas};

endmodule

`default_nettype wire

>>> rtl/mftt_back.sv
// back end: per-motor turn tracking (read-modify-write) and angle computation
// depends on mftt_pkg
`default_nettype none

module mftt_back
    import mftt_pkg::*;
#(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF,
    localparam int SLOT_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1,
    localparam int MID_W  = SLOT_W + $bits(t_meas)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_empty,
    input  wire logic [MID_W-1:0] i_q_data,
    output logic                  o_q_pop,
    input  wire logic             i_out_full,
    output logic                  o_out_push,
    output t_result               o_out_data
);

    localparam logic signed [POS_W:0]    JUMP_POS = (POS_W+1)'(HALF_TURN);
    localparam logic signed [POS_W:0]    JUMP_NEG = -JUMP_POS;
    localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
    localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};
    localparam logic signed [ANGLE_W-1:0] DEG_S   = ANGLE_W'(DEG_PER_TURN);
    localparam logic        [ANGLE_W-1:0] DEG_U   = ANGLE_W'(DEG_PER_TURN);

    logic        [POS_W-1:0]  r_prev_pos [MOTOR_COUNT];
    logic signed [TURN_W-1:0] r_turns    [MOTOR_COUNT];

    logic                     r_s1_valid;
    logic [SLOT_W-1:0]        r_s1_slot;
    t_meas                    r_s1_meas;
    logic signed [TURN_W-1:0] r_s1_turns;

    logic [SLOT_W-1:0]        slot;
    t_meas                    meas;
    logic [POS_W-1:0]         prev_pos;
    logic signed [TURN_W-1:0] turns_old, n_turns;
    logic signed [POS_W:0]    diff;
    logic                     s1_leave;

    logic signed [ANGLE_W-1:0] turn_deg;
    logic        [ANGLE_W-1:0] pos_prod, frac_deg;

    assign slot = i_q_data[MID_W-1 -: SLOT_W];
    assign meas = t_meas'(i_q_data[$bits(t_meas)-1:0]);

    assign s1_leave = r_s1_valid && !i_out_full;
    assign o_q_pop  = !i_q_empty && (!r_s1_valid || s1_leave);

    assign prev_pos  = r_prev_pos[slot];
    assign turns_old = r_turns[slot];
    assign diff      = $signed({1'b0, meas.position}) - $signed({1'b0, prev_pos});

    // rise past half a turn wraps backward, fall past half a turn wraps forward
    always_comb begin
        n_turns = turns_old;
        if (diff > JUMP_POS) begin
            if (turns_old != TURN_MIN) begin
                n_turns = turns_old - 1'b1;
            end
        end else if (diff < JUMP_NEG) begin
            if (turns_old != TURN_MAX) begin
                n_turns = turns_old + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                r_prev_pos[k] <= '0;
                r_turns[k]    <= '0;
            end
            r_s1_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_prev_pos[slot] <= meas.position;
                r_turns[slot]    <= n_turns;
                r_s1_valid       <= 1'b1;
            end else if (s1_leave) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_slot  <= slot;
            r_s1_meas  <= meas;
            r_s1_turns <= n_turns;
        end
    end

    // angle = turns * 360 + floor(position * 360 / 8192)
    assign turn_deg = $signed({{(ANGLE_W-TURN_W){r_s1_turns[TURN_W-1]}}, r_s1_turns}) * DEG_S;
    assign pos_prod = ANGLE_W'(r_s1_meas.position) * DEG_U;
    assign frac_deg = pos_prod >> COUNT_SHIFT;

    assign o_out_push = s1_leave;

    always_comb begin
        o_out_data.motor_index      = MOTOR_IX_W'(r_s1_slot);
        o_out_data.encoder_position = r_s1_meas.position;
        o_out_data.shaft_speed      = r_s1_meas.speed;
        o_out_data.measured_current = r_s1_meas.current;
        o_out_data.temperature      = r_s1_meas.temperature;
        o_out_data.turn_count       = r_s1_turns;
        o_out_data.angle_degrees    = turn_deg + $signed(frac_deg);
    end

endmodule

`default_nettype wire

>>> rtl/motor_feedback_turn_tracker.sv
// top level of the motor feedback turn tracker: configuration register, front end,
// queues and back end; depends on mftt_pkg, mftt_queue, mftt_front, mftt_back
`default_nettype none

// Decodes motor feedback CAN frames and tracks multi-turn position per motor.
// A frame is a transfer on the input queue side (push/full); its id is matched
// against first_motor_id .. first_motor_id + MOTOR_COUNT - 1 and frames outside
// that range are dropped with no result and no state change. A matching frame
// yields one result transfer (empty/pop) carrying the decoded fields, the
// motor's saturating turn counter and the angle in whole degrees. The block
// takes one frame per clock while full is low; a result passes through the
// front queue, then the turn-tracking stage, then the result queue before
// it reaches the output ports. Each motor's turn state is updated as a
// read-modify-write of a small register file, so back-to-back frames for the
// same motor are exact. Both queues are two entries deep, so either side may
// stall without stopping the other until the queues fill. first_motor_id sits
// at byte address 0 of the APB port, reads back, and resets to 513; write it
// only while the block is idle.

module motor_feedback_turn_tracker
    import mftt_pkg::*;
#(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    // configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic      [APB_DATA_W-1:0]  prdata,
    output logic                        pready,

    // frame input
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [ID_W-1:0]        i_frame_id,
    input  wire logic [7:0]             i_byte0,
    input  wire logic [7:0]             i_byte1,
    input  wire logic [7:0]             i_byte2,
    input  wire logic [7:0]             i_byte3,
    input  wire logic [7:0]             i_byte4,
    input  wire logic [7:0]             i_byte5,
    input  wire logic [7:0]             i_byte6,

    // result output
    output logic                        empty,
    input  wire logic                   pop,
    output logic [MOTOR_IX_W-1:0]       o_motor_index,
    output logic [15:0]                 o_encoder_position,
    output logic signed [15:0]          o_shaft_speed,
    output logic signed [15:0]          o_measured_current,
    output logic [7:0]                  o_temperature,
    output logic signed [TURN_W-1:0]    o_turn_count,
    output logic signed [ANGLE_W-1:0]   o_angle_degrees
);

    localparam int SLOT_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int MID_W  = SLOT_W + $bits(t_meas);
    localparam int RES_W  = $bits(t_result);

    // configuration register
    logic [ID_W-1:0] r_first_id;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_FIRST_MOTOR_ID);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_id <= FIRST_MOTOR_ID_RESET;
        end else if (cfg_wr) begin
            r_first_id <= pwdata[ID_W-1:0];
        end
    end

    // read back: only the base id register decodes
    always_comb begin
        prdata = '0;
        if (paddr == REG_FIRST_MOTOR_ID) begin
            prdata = APB_DATA_W'(r_first_id);
        end
    end

    // front end to the id-matching queue
    logic             mid_push, mid_full, mid_pop, mid_empty;
    logic [MID_W-1:0] mid_wdata, mid_rdata;

    mftt_front #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_front (
        .i_first_id (r_first_id),
        .i_push     (push),
        .o_full     (full),
        .i_frame_id (i_frame_id),
        .i_byte0    (i_byte0),
        .i_byte1    (i_byte1),
        .i_byte2    (i_byte2),
        .i_byte3    (i_byte3),
        .i_byte4    (i_byte4),
        .i_byte5    (i_byte5),
        .i_byte6    (i_byte6),
        .o_q_push   (mid_push),
        .o_q_data   (mid_wdata),
        .i_q_full   (mid_full)
    );

    // queue between front and back end
    mftt_queue #(
        .W     (MID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_wdata),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_rdata),
        .o_empty (mid_empty)
    );

    // turn tracking and angle
    logic    res_push, res_full;
    t_result res_wdata, res_rdata;

    mftt_back #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (mid_empty),
        .i_q_data   (mid_rdata),
        .o_q_pop    (mid_pop),
        .i_out_full (res_full),
        .o_out_push (res_push),
        .o_out_data (res_wdata)
    );

    // result queue, head drives the output ports
    logic [RES_W-1:0] res_rbits;

    mftt_queue #(
        .W     (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_wdata),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_rbits),
        .o_empty (empty)
    );

    assign res_rdata          = t_result'(res_rbits);
    assign o_motor_index      = res_rdata.motor_index;
    assign o_encoder_position = res_rdata.encoder_position;
    assign o_shaft_speed      = res_rdata.shaft_speed;
    assign o_measured_current = res_rdata.measured_current;
    assign o_temperature      = res_rdata.temperature;
    assign o_turn_count       = res_rdata.turn_count;
    assign o_angle_degrees    = res_rdata.angle_degrees;

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for motor_feedback_turn_tracker: frame driver, result monitor,
// in-bench turn tracking predictor and APB configuration writes with readback
// depends on mftt_pkg and the motor_feedback_turn_tracker rtl
`timescale 1ns / 100ps

module tb;
    import mftt_pkg::*;

    // bench constants
    localparam int MOTORS         = 7;
    localparam int HALF_REV       = 4096;
    localparam int COUNTS_PER_REV = 8192;
    localparam int DEG_PER_REV    = 360;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 12;     // idle wait after the last owed result
    localparam int STALL_LIMIT    = 3000;   // cycles with no transfer on either side
    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
    localparam int HOLD_AFTER     = 1000;   // frames accepted before the hold-off starts
    localparam int IDLE_PCT       = 31;
    localparam int SWEEP_STEPS    = 25;     // turns walked per motor in the counter sweep

    // one frame waiting to be offered
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [15:0]     pos;
        logic [39:0]     tail;   // byte2 .. byte6, byte2 highest
    } t_frame;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // configuration port
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;

    // frame side
    logic            push       = 1'b0;
    wire             full;
    logic [ID_W-1:0] i_frame_id = '0;
    logic [7:0]      i_byte0    = '0;
    logic [7:0]      i_byte1    = '0;
    logic [7:0]      i_byte2    = '0;
    logic [7:0]      i_byte3    = '0;
    logic [7:0]      i_byte4    = '0;
    logic [7:0]      i_byte5    = '0;
    logic [7:0]      i_byte6    = '0;

    // result side
    wire                       empty;
    logic                      pop = 1'b0;
    wire [MOTOR_IX_W-1:0]      o_motor_index;
    wire [15:0]                o_encoder_position;
    wire signed [15:0]         o_shaft_speed;
    wire signed [15:0]         o_measured_current;
    wire [7:0]                 o_temperature;
    wire signed [TURN_W-1:0]   o_turn_count;
    wire signed [ANGLE_W-1:0]  o_angle_degrees;

    // predictor state: configured base id, last position and turn counter per motor
    logic [ID_W-1:0]    base_id;
    logic [15:0]        last_pos [MOTORS];
    logic signed [15:0] turn_ctr [MOTORS];

    // stimulus side shadow of the last position sent to each motor
    int sent_pos [MOTORS];

    t_frame  frame_backlog [$];
    t_result feedback_due  [$];

    int   mismatches      = 0;
    int   frames_accepted = 0;
    int   idle_cycles     = 0;
    int   cyc             = 0;
    int   hold_left       = 0;
    logic hold_done       = 1'b0;
    logic frame_taken     = 1'b0;
    logic quiet_stretch;

    // a window where neither side idles
    assign quiet_stretch = (cyc >= 500) && (cyc < 1300);

    motor_feedback_turn_tracker u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .push               (push),
        .full               (full),
        .i_frame_id         (i_frame_id),
        .i_byte0            (i_byte0),
        .i_byte1            (i_byte1),
        .i_byte2            (i_byte2),
        .i_byte3            (i_byte3),
        .i_byte4            (i_byte4),
        .i_byte5            (i_byte5),
        .i_byte6            (i_byte6),
        .empty              (empty),
        .pop                (pop),
        .o_motor_index      (o_motor_index),
        .o_encoder_position (o_encoder_position),
        .o_shaft_speed      (o_shaft_speed),
        .o_measured_current (o_measured_current),
        .o_temperature      (o_temperature),
        .o_turn_count       (o_turn_count),
        .o_angle_degrees    (o_angle_degrees)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // turn tracking for the frame currently on the input ports; queues the
    // feedback it owes, or nothing when the id is outside the motor range
    task automatic decode_frame();
        int      slot;
        int      pos;
        int      jump;
        int      turns;
        t_result fb;
        slot = int'(i_frame_id) - int'(base_id);
        if (slot < 0 || slot >= MOTORS) return;
        pos   = int'({i_byte0, i_byte1});
        jump  = pos - int'(last_pos[slot]);
        turns = int'(turn_ctr[slot]);
        // rising jump past half a turn means a backward wrap, falling means forward
        if (jump > HALF_REV && turns > -32768) begin
            turns--;
        end else if (jump < -HALF_REV && turns < 32767) begin
            turns++;
        end
        last_pos[slot] = 16'(pos);
        turn_ctr[slot] = 16'(turns);
        fb.motor_index      = MOTOR_IX_W'(slot);
        fb.encoder_position = 16'(pos);
        fb.shaft_speed      = {i_byte2, i_byte3};
        fb.measured_current = {i_byte4, i_byte5};
        fb.temperature      = i_byte6;
        fb.turn_count       = 16'(turns);
        // position is never negative, so the division truncates toward zero
        fb.angle_degrees    = ANGLE_W'(turns * DEG_PER_REV + (pos * DEG_PER_REV) / COUNTS_PER_REV);
        feedback_due.push_back(fb);
    endtask

    // queue one frame and keep the shadow of sent positions up to date
    task automatic queue_frame(input int id, input int pos, input logic [39:0] tail);
        t_frame f;
        int     slot;
        f.id   = ID_W'(id);
        f.pos  = 16'(pos);
        f.tail = tail;
        slot = id - int'(base_id);
        if (slot >= 0 && slot < MOTORS) sent_pos[slot] = pos;
        frame_backlog.push_back(f);
    endtask

    function automatic logic [39:0] rand_tail();
        return {8'($urandom), $urandom};
    endfunction

    // random traffic: mostly motor frames that walk across the wrap point,
    // plus frames just outside the id range and random ids
    task automatic stir_frames(input int n);
        int top;
        int slot;
        int prev;
        int pos;
        int id;
        int step;
        top = (2047 - int'(base_id) < MOTORS - 1) ? 2047 - int'(base_id) : MOTORS - 1;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 80) begin
                slot = $urandom_range(top);
                prev = sent_pos[slot];
                case ($urandom_range(9)) inside
                    [0:4]: begin
                        pos = (prev + $urandom_range(10000) - 5000) % COUNTS_PER_REV;
                        if (pos < 0) pos += COUNTS_PER_REV;
                    end
                    [5:6]: begin
                        // right at the half-turn threshold, either side of it
                        step = HALF_REV + $urandom_range(1);
                        if ($urandom_range(1)) step = -step;
                        pos = prev + step;
                        if (pos < 0 || pos > 65535) pos = prev - step;
                    end
                    7: pos = $urandom_range(65535);
                    8: begin
                        case ($urandom_range(3))
                            0: pos = 0;
                            1: pos = COUNTS_PER_REV - 1;
                            2: pos = COUNTS_PER_REV;
                            default: pos = 65535;
                        endcase
                    end
                    default: pos = $urandom_range(COUNTS_PER_REV - 1);
                endcase
                queue_frame(int'(base_id) + slot, pos, rand_tail());
            end else begin
                case ($urandom_range(2))
                    0: id = (base_id > 0) ? int'(base_id) - 1 : $urandom_range(2047);
                    1: id = (int'(base_id) + top + 1 <= 2047) ? int'(base_id) + top + 1
                                                              : $urandom_range(2047);
                    default: id = $urandom_range(2047);
                endcase
                queue_frame(id, $urandom_range(65535), rand_tail());
            end
        end
    endtask

    // walk one motor's counter up and another's down, two frames per turn:
    // a fall of 4097 followed by a rise of exactly 4096, and mirrored
    task automatic sweep_counters(input int up_slot, input int down_slot);
        int hi;
        for (int k = 0; k < SWEEP_STEPS; k++) begin
            hi = 65535 - k;
            queue_frame(int'(base_id) + up_slot, hi - HALF_REV - 1, rand_tail());
            queue_frame(int'(base_id) + up_slot, hi - 1, rand_tail());
        end
        for (int k = 0; k < SWEEP_STEPS; k++) begin
            queue_frame(int'(base_id) + down_slot, k + HALF_REV + 1, rand_tail());
            queue_frame(int'(base_id) + down_slot, k + 1, rand_tail());
        end
    endtask

    // sender pause: wait for every owed result, then let dropped frames clear
    task automatic settle();
        while (frame_backlog.size() != 0 || push || feedback_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write first_motor_id, read it back, and move the predictor to the new base
    task automatic set_base_id(input int value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_FIRST_MOTOR_ID;
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(value)) begin
            flag_mismatch("first_motor_id readback", value, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        base_id = ID_W'(value);
    endtask

    // frame driver: holds an offered frame until its transfer, then takes the
    // next one from the backlog or idles
    always @(negedge i_clk) begin : frame_driver
        logic   offer;
        t_frame nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || frame_taken) begin
            offer = (frame_backlog.size() != 0) &&
                    (quiet_stretch || $urandom_range(99) >= IDLE_PCT);
            if (offer) begin
                nxt = frame_backlog.pop_front();
                i_frame_id <= nxt.id;
                i_byte0    <= nxt.pos[15:8];
                i_byte1    <= nxt.pos[7:0];
                i_byte2    <= nxt.tail[39:32];
                i_byte3    <= nxt.tail[31:24];
                i_byte4    <= nxt.tail[23:16];
                i_byte5    <= nxt.tail[15:8];
                i_byte6    <= nxt.tail[7:0];
            end
            push <= offer;
        end
    end

    // result receiver: random pops, plus one long hold-off so the block backs up
    always @(negedge i_clk) begin : result_receiver
        if (hold_left > 0) begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && frames_accepted >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            pop       <= 1'b0;
        end else begin
            pop <= quiet_stretch || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: predicts on every frame transfer, checks every result transfer
    always @(posedge i_clk) begin : frame_monitor
        t_result want;
        logic    moved;
        moved = 1'b0;
        cyc <= cyc + 1;
        frame_taken <= i_rst_n && push && !full;
        if (i_rst_n && push && !full) begin
            decode_frame();
            frames_accepted++;
            moved = 1'b1;
        end
        if (i_rst_n && pop && !empty) begin
            moved = 1'b1;
            if (feedback_due.size() == 0) begin
                flag_mismatch("result with no frame behind it, motor_index", -1, o_motor_index);
            end else begin
                want = feedback_due.pop_front();
                if (o_motor_index !== want.motor_index)
                    flag_mismatch("motor_index", want.motor_index, o_motor_index);
                if (o_encoder_position !== want.encoder_position)
                    flag_mismatch("encoder_position", want.encoder_position, o_encoder_position);
                if (o_shaft_speed !== want.shaft_speed)
                    flag_mismatch("shaft_speed", want.shaft_speed, o_shaft_speed);
                if (o_measured_current !== want.measured_current)
                    flag_mismatch("measured_current", want.measured_current, o_measured_current);
                if (o_temperature !== want.temperature)
                    flag_mismatch("temperature", want.temperature, o_temperature);
                if (o_turn_count !== want.turn_count)
                    flag_mismatch("turn_count", want.turn_count, o_turn_count);
                if (o_angle_degrees !== want.angle_degrees)
                    flag_mismatch("angle_degrees", want.angle_degrees, o_angle_degrees);
            end
        end
        idle_cycles <= moved ? 0 : idle_cycles + 1;
    end

    // watchdog on cycles with no transfer at all
    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("motor_feedback_turn_tracker verification failed");
        $finish;
    end

    initial begin : stimulus
        int new_base;
        base_id = FIRST_MOTOR_ID_RESET;
        for (int k = 0; k < MOTORS; k++) begin
            last_pos[k] = '0;
            turn_ctr[k] = '0;
            sent_pos[k] = 0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames at the reset base 513, motors on ids 513 to 519
        queue_frame(513, 16'h0000, 40'h00_0000_0000);     // first frame, no jump
        queue_frame(513, 16'h1001, 40'h7F_FF80_00FF);     // rise past half a turn, speed max
        queue_frame(513, 16'h0001, 40'h80_007F_FF00);     // fall of exactly half a turn
        queue_frame(513, 16'h0000, 40'hFF_FFFF_FFFF);     // all payload bits set
        queue_frame(514, 16'h1000, rand_tail());          // first frame at exactly half a turn
        queue_frame(514, 16'hFFFF, 40'hFF_FFFF_FFFF);     // position above one turn
        queue_frame(514, 16'h0000, rand_tail());          // big fall, counter up
        queue_frame(515, 16'h1001, rand_tail());          // first frame above half a turn
        queue_frame(519, 16'h2000, rand_tail());          // last motor, position 8192
        queue_frame(512, 16'h1234, rand_tail());          // just below the base
        queue_frame(520, 16'h1234, rand_tail());          // just past the last motor
        queue_frame(0, 16'hFFFF, rand_tail());            // lowest id
        queue_frame(2047, 16'h0000, rand_tail());         // highest id
        queue_frame(516, 16'hAA55, 40'hAA_55AA_5555);     // alternating bits
        queue_frame(516, 16'h55AA, 40'h55_AA55_AAAA);
        queue_frame(517, 16'h1FFF, rand_tail());          // top of a nominal turn
        queue_frame(517, 16'h0000, rand_tail());          // wrap forward
        queue_frame(518, 16'h1001, rand_tail());
        queue_frame(518, 16'h0000, rand_tail());
        queue_frame(518, 16'h1000, rand_tail());          // rise of exactly half a turn
        stir_frames(200);

        // counters walking in both directions
        sweep_counters(5, 6);
        settle();

        // base id settings: both extremes, ranges running past the top id, a random one, then the reset base
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: new_base = 0;
                1: new_base = 2047 - (MOTORS - 1);
                2: new_base = 2047;
                3: new_base = 2045;
                4: new_base = $urandom_range(1, 2040);
                default: new_base = int'(FIRST_MOTOR_ID_RESET);
            endcase
            set_base_id(new_base);
            stir_frames(240);
            settle();
        end

        if (mismatches == 0 && feedback_due.size() == 0) begin
            $display("motor_feedback_turn_tracker verification clean");
        end else begin
            $display("motor_feedback_turn_tracker verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/mftt_pkg.sv
rtl/mftt_queue.sv
rtl/mftt_front.sv
rtl/mftt_back.sv
rtl/motor_feedback_turn_tracker.sv
tb/tb.sv
